FILE: rtl/allocator_size_class_mapper_core_assert.svh
// Assertion macros shared by the size-class mapper RTL.
`ifndef ALLOCATOR_SIZE_CLASS_MAPPER_CORE_ASSERT_SVH
`define ALLOCATOR_SIZE_CLASS_MAPPER_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define ACM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true
`define ACM_NEVER(lbl, cond, msg) \
  `ACM_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/acm_pkg.sv
// Shared types and constants of the size-class mapper.
package acm_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam logic [2:0] REG_BASE_TINY   = 3'd0;
  localparam logic [2:0] REG_BASE_SMALL  = 3'd1;
  localparam logic [2:0] REG_BASE_MEDIUM = 3'd2;
  localparam logic [2:0] REG_BASE_LARGE  = 3'd3;
  localparam logic [2:0] REG_BASE_HUGE   = 3'd4;
  localparam logic [2:0] REG_CACHE_LIMIT = 3'd5;
  localparam logic [2:0] REG_PAGE_BYTES  = 3'd6;

  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned LimitW    = 24;
  localparam int unsigned PageBytesW = 20;
  localparam int unsigned BatchW    = 10;
  localparam int unsigned PagesW    = 33;
  localparam int unsigned ReqW      = 32;

  localparam logic [BatchW-1:0] BatchMin = 10'd2;
  localparam logic [BatchW-1:0] BatchMax = 10'd512;

  // sideband carried along the dividers
  typedef struct packed {
    logic [7:0] cls;
    status_e    status;
  } acm_tag_t;

endpackage

FILE: rtl/acm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
module acm_div_pipe import acm_pkg::*; #(
  parameter int unsigned NumW  = 24,
  parameter int unsigned DenW  = 32,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quot_o,
  output logic [SideW-1:0] side_o
);

  logic [NumW:0]    vld;
  logic [NumW-1:0]  num  [NumW+1];
  logic [NumW-1:0]  quot [NumW+1];
  logic [DenW-1:0]  rem  [NumW+1];
  logic [DenW-1:0]  den  [NumW+1];
  logic [SideW-1:0] side [NumW+1];

  assign vld[0]  = valid_i;
  assign num[0]  = num_i;
  assign quot[0] = '0;
  assign rem[0]  = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW:0]   trial;
    logic            ge;
    logic [DenW-1:0] rem_d;
    logic [NumW-1:0] quot_d;

    always_comb begin
      trial  = {rem[k], num[k][NumW-1-k]};
      ge     = (trial >= {1'b0, den[k]});
      rem_d  = ge ? DenW'(trial - {1'b0, den[k]}) : DenW'(trial);
      quot_d = quot[k];
      quot_d[NumW-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      num[k+1]  <= num[k];
      quot[k+1] <= quot_d;
      rem[k+1]  <= rem_d;
      den[k+1]  <= den[k];
      side[k+1] <= side[k];
    end
  end

  assign valid_o = vld[NumW];
  assign quot_o  = quot[NumW];
  assign side_o  = side[NumW];

endmodule

FILE: rtl/allocator_size_class_mapper_core.sv
// Top level of the allocation size-class mapper pipeline.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  request   | start_i / busy_o     | req_size_i
//  result    | valid_o (strobe)     | class_index_o batch_count_o page_count_o status_o
//  config    | cfg_we_i             | cfg_idx_i cfg_wdata_i
//
// One transaction enters per cycle; busy_o is never raised.
// Registered steps in order: decode, batch divider, multiply/clamp, page divider
//   and output.
// The page divider, one quotient bit per stage, sets the depth.
// Reset clears all valid bits and loads the default config values.
// The result strobe lasts one cycle; the receiver cannot stall.
`include "allocator_size_class_mapper_core_assert.svh"

module allocator_size_class_mapper_core import acm_pkg::*; #(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [ReqW-1:0]     req_size_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                valid_o,
  output logic [7:0]          class_index_o,
  output logic [BatchW-1:0]   batch_count_o,
  output logic [PagesW-1:0]   page_count_o,
  output logic [1:0]          status_o
);

  localparam int unsigned ProdW = SIZE_WIDTH + BatchW;

  // ---------------- configuration registers ----------------
  logic [7:0]            base_tiny_q, base_small_q, base_medium_q, base_large_q, base_huge_q;
  logic [LimitW-1:0]     limit_q;
  logic [PageBytesW-1:0] page_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_tiny_q   <= 8'd0;
      base_small_q  <= 8'd16;
      base_medium_q <= 8'd72;
      base_large_q  <= 8'd128;
      base_huge_q   <= 8'd184;
      limit_q       <= 24'd262144;
      page_bytes_q  <= 20'd8192;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_TINY:   base_tiny_q   <= cfg_wdata_i[7:0];
        REG_BASE_SMALL:  base_small_q  <= cfg_wdata_i[7:0];
        REG_BASE_MEDIUM: base_medium_q <= cfg_wdata_i[7:0];
        REG_BASE_LARGE:  base_large_q  <= cfg_wdata_i[7:0];
        REG_BASE_HUGE:   base_huge_q   <= cfg_wdata_i[7:0];
        REG_CACHE_LIMIT: limit_q       <= cfg_wdata_i[LimitW-1:0];
        REG_PAGE_BYTES:  page_bytes_q  <= cfg_wdata_i[PageBytesW-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  assign busy_o = 1'b0;

  // ---------------- stage 0: range decode and class index ----------------
  logic [SIZE_WIDTH-1:0] size;
  logic [18:0]           off;
  logic [18:0]           step;
  logic [7:0]            base;
  logic [7:0]            cls_d;
  status_e               status_d;

  assign size = SIZE_WIDTH'(req_size_i);

  always_comb begin
    off      = '0;
    step     = '0;
    base     = '0;
    status_d = ST_OK;
    if (size == '0) begin
      status_d = ST_ZERO;
    end else if (size < SIZE_WIDTH'(128)) begin
      off  = 19'(size);
      step = 19'((off + 19'd7) >> 3);
      base = base_tiny_q;
    end else if (size < SIZE_WIDTH'(1024)) begin
      off  = 19'(size - SIZE_WIDTH'(128));
      step = 19'((off + 19'd15) >> 4);
      base = base_small_q;
    end else if (size < SIZE_WIDTH'(8 * 1024)) begin
      off  = 19'(size - SIZE_WIDTH'(1024));
      step = 19'((off + 19'd127) >> 7);
      base = base_medium_q;
    end else if (size < SIZE_WIDTH'(64 * 1024)) begin
      off  = 19'(size - SIZE_WIDTH'(8 * 1024));
      step = 19'((off + 19'd1023) >> 10);
      base = base_large_q;
    end else if (size < SIZE_WIDTH'(256 * 1024)) begin
      off  = 19'(size - SIZE_WIDTH'(64 * 1024));
      step = 19'((off + 19'd8191) >> 13);
      base = base_huge_q;
    end else begin
      status_d = ST_RANGE;
    end
    // range start (offset zero) wraps to base - 1
    cls_d = (status_d == ST_OK) ? 8'(step[7:0] - 8'd1 + base) : 8'd0;
  end

  logic                  s0_valid_q;
  logic [SIZE_WIDTH-1:0] s0_size_q;
  acm_tag_t              s0_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_size_q       <= size;
    s0_tag_q.cls    <= cls_d;
    s0_tag_q.status <= status_d;
  end

  // ---------------- batch divider: limit / size ----------------
  localparam int unsigned Side1W = $bits(acm_tag_t) + SIZE_WIDTH;

  logic                  d1_valid;
  logic [LimitW-1:0]     d1_quot;
  logic [Side1W-1:0]     d1_side;
  acm_tag_t              d1_tag;
  logic [SIZE_WIDTH-1:0] d1_size;

  acm_div_pipe #(
    .NumW  (LimitW),
    .DenW  (SIZE_WIDTH),
    .SideW (Side1W)
  ) u_div_batch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_valid_q),
    .num_i   (limit_q),
    .den_i   (s0_size_q),
    .side_i  ({s0_tag_q, s0_size_q}),
    .valid_o (d1_valid),
    .quot_o  (d1_quot),
    .side_o  (d1_side)
  );

  assign {d1_tag, d1_size} = d1_side;

  // ---------------- clamp and batch bytes ----------------
  logic [BatchW-1:0] batch_d;

  always_comb begin
    if (d1_quot < LimitW'(BatchMin)) begin
      batch_d = BatchMin;
    end else if (d1_quot > LimitW'(BatchMax)) begin
      batch_d = BatchMax;
    end else begin
      batch_d = BatchW'(d1_quot);
    end
  end

  logic              m_valid_q;
  logic [ProdW-1:0]  m_prod_q;
  logic [BatchW-1:0] m_batch_q;
  acm_tag_t          m_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m_prod_q  <= ProdW'(batch_d) * ProdW'(d1_size);
    m_batch_q <= batch_d;
    m_tag_q   <= d1_tag;
  end

  // ---------------- page divider: batch bytes / page bytes ----------------
  localparam int unsigned Side2W = $bits(acm_tag_t) + BatchW;

  logic [PageBytesW-1:0] page_div;
  logic                  d2_valid;
  logic [ProdW-1:0]      d2_quot;
  logic [Side2W-1:0]     d2_side;
  acm_tag_t              d2_tag;
  logic [BatchW-1:0]     d2_batch;

  // a page size of zero counts as one byte
  assign page_div = (page_bytes_q == '0) ? PageBytesW'(1) : page_bytes_q;

  acm_div_pipe #(
    .NumW  (ProdW),
    .DenW  (PageBytesW),
    .SideW (Side2W)
  ) u_div_pages (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid_q),
    .num_i   (m_prod_q),
    .den_i   (page_div),
    .side_i  ({m_tag_q, m_batch_q}),
    .valid_o (d2_valid),
    .quot_o  (d2_quot),
    .side_o  (d2_side)
  );

  assign {d2_tag, d2_batch} = d2_side;

  // ---------------- output register ----------------
  logic              out_valid_q;
  logic [7:0]        out_cls_q;
  logic [BatchW-1:0] out_batch_q;
  logic [PagesW-1:0] out_pages_q;
  status_e           out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cls_q    <= d2_tag.cls;
    out_status_q <= d2_tag.status;
    if (d2_tag.status == ST_ZERO) begin
      out_batch_q <= '0;
      out_pages_q <= '0;
    end else begin
      out_batch_q <= d2_batch;
      out_pages_q <= (d2_quot == '0) ? PagesW'(1) : PagesW'(d2_quot);
    end
  end

  assign valid_o       = out_valid_q;
  assign class_index_o = out_cls_q;
  assign batch_count_o = out_batch_q;
  assign page_count_o  = out_pages_q;
  assign status_o      = out_status_q;

  // ---------------- checks ----------------
  logic out_all_zero;
  logic out_batch_legal;

  assign out_all_zero    = (batch_count_o == '0) && (page_count_o == '0) &&
                           (class_index_o == '0);
  assign out_batch_legal = (batch_count_o >= BatchMin) && (batch_count_o <= BatchMax);

  `ACM_NEVER(a_status_code, valid_o && (status_o == 2'd3), "status code out of range")
  `ACM_ASSERT(a_zero_result, (valid_o && (status_o == ST_ZERO)) |-> out_all_zero, "size zero gave nonzero result")
  `ACM_ASSERT(a_batch_range, (valid_o && (status_o != ST_ZERO)) |-> out_batch_legal, "batch count outside clamp")
  `ACM_ASSERT(a_range_class, (valid_o && (status_o == ST_RANGE)) |-> (class_index_o == '0), "class index set on oversize request")

endmodule
